// ----- hdl/fbsa_pkg.sv -----
package fbsa_pkg;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [ADDR_W-1:0] BASE_ADDR_RESET = 32'd16384;

    // action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_OUT_OF_MEM = 2'd1;
    localparam logic [1:0] STATUS_MISALIGNED = 2'd2;
    localparam logic [1:0] STATUS_FULL       = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  block_address;
        logic [1:0]         status;
        logic [COUNT_W-1:0] used_blocks;
        logic [COUNT_W-1:0] free_blocks;
    } rsp_t;

endpackage

// ----- hdl/fbsa_stack_mem.sv -----
module fbsa_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [fbsa_pkg::ADDR_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [fbsa_pkg::ADDR_W-1:0] rdata
);
    import fbsa_pkg::*;

    logic [ADDR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/free_block_stack_allocator.sv -----
// Free block stack allocator. A request is taken when start is high and busy is low; its
// single result appears on result for exactly one cycle with done high, and the receiver
// cannot stall it. Free, init with no blocks, alloc on an empty stack and unused actions
// answer straight from the idle state; a successful alloc passes through S_READ because
// the popped address comes from the registered stack memory read; init holds busy in S_INIT
// until every block is written, one stack entry a cycle through the single memory write port.
// busy is low while a result is shown, so a new request may be taken in that same cycle.
// Configuration writes are registered, so a request taken in that cycle sees the old values.
module free_block_stack_allocator #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fbsa_pkg::req_t                 request,
    output logic                           done,
    output fbsa_pkg::rsp_t                 result,
    input  logic                           cfg_write,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbsa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbsa_pkg::*;

    localparam int CW     = $clog2(MAX_BLOCKS + 1);
    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int BB_LOG = $clog2(BLOCK_BYTES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_INIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] mem_size_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [CW-1:0]     top_reg, top_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [AW-1:0]     init_idx_reg, init_idx_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic              done_reg, done_next;
    rsp_t              result_reg, result_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [ADDR_W-1:0] mem_rdata;

    logic [ADDR_W-1:0] blocks_raw;
    logic [CW-1:0]     init_count;
    logic [ADDR_W-1:0] res_addr;
    logic [1:0]        res_status;

    fbsa_stack_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_stack_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // block count from memory size, saturated
    always_comb
    begin
        blocks_raw = mem_size_reg >> BB_LOG;
        if (blocks_raw > ADDR_W'(MAX_BLOCKS))
        begin
            init_count = CW'(MAX_BLOCKS);
        end
        else
        begin
            init_count = CW'(blocks_raw);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        init_idx_next  = init_idx_reg;
        init_addr_next = init_addr_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        res_addr       = '0;
        res_status     = STATUS_OK;

        mem_we    = 1'b0;
        mem_waddr = init_idx_reg;
        mem_wdata = init_addr_reg;
        mem_re    = 1'b0;
        mem_raddr = AW'(top_reg - CW'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.action)
                        ACT_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                res_status = STATUS_OUT_OF_MEM;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                // pop: pre-decrement, then read the entry
                                top_next   = top_reg - CW'(1);
                                used_next  = used_reg + CW'(1);
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        ACT_FREE:
                        begin
                            done_next = 1'b1;
                            if (request.free_address[BB_LOG-1:0] != '0)
                            begin
                                res_status = STATUS_MISALIGNED;
                            end
                            else if (top_reg >= total_reg || top_reg >= CW'(MAX_BLOCKS))
                            begin
                                res_status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(top_reg);
                                mem_wdata = request.free_address;
                                top_next  = top_reg + CW'(1);
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - CW'(1);
                                end
                            end
                        end
                        ACT_INIT:
                        begin
                            total_next     = init_count;
                            top_next       = init_count;
                            used_next      = '0;
                            init_idx_next  = '0;
                            init_addr_next = base_reg;
                            if (init_count == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_addr   = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                mem_we         = 1'b1;
                init_idx_next  = init_idx_reg + AW'(1);
                init_addr_next = init_addr_reg + ADDR_W'(BLOCK_BYTES);
                if (CW'(init_idx_reg) == total_reg - CW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            result_next.block_address = res_addr;
            result_next.status        = res_status;
            result_next.used_blocks   = COUNT_W'(used_next);
            result_next.free_blocks   = COUNT_W'(top_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            top_reg      <= '0;
            used_reg     <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
            mem_size_reg <= '0;
            base_reg     <= BASE_ADDR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            if (cfg_write && cfg_index == REG_MEM_SIZE)
            begin
                mem_size_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_BASE_ADDR)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        init_idx_reg  <= init_idx_next;
        init_addr_reg <= init_addr_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
